[rtl/i2c_eeprom_master_assert.svh]
// Assertion macros for the EEPROM master
`ifndef I2C_EEPROM_MASTER_ASSERT_SVH
`define I2C_EEPROM_MASTER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define IEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define IEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/iem_pkg.sv]
// ----------------------------------------------------------------------------
// iem_pkg
// Shared types and constants for the I2C EEPROM master.
// ----------------------------------------------------------------------------
package iem_pkg;

  localparam int PAGE_BYTES_DEF = 16;
  localparam int ADDR_WIDTH_DEF = 11;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_RDB   = 3'd1;
  localparam logic [2:0] MODE_WRB   = 3'd2;
  localparam logic [2:0] MODE_RDP   = 3'd3;
  localparam logic [2:0] MODE_WRP   = 3'd4;
  localparam logic [2:0] MODE_LOAD  = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DEVNACK = 3'd1;
  localparam logic [2:0] ST_WANACK  = 3'd2;
  localparam logic [2:0] ST_RDNACK  = 3'd3;
  localparam logic [2:0] ST_DATNACK = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  localparam logic       CFG_PHASE  = 1'b0;
  localparam logic       CFG_LIMIT  = 1'b1;

  localparam logic [7:0] DEV_WR     = 8'ha0;
  localparam logic [7:0] DEV_RD     = 8'ha1;

  // One tick as queued between front and back
  typedef struct packed {
    logic [2:0]  mode;
    logic [10:0] address;
    logic [7:0]  write_data;
    logic [3:0]  buffer_index;
    logic        scl_in;
    logic        sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] read_data;
    logic       read_valid;
    logic [3:0] read_index;
  } res_t;

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001, S_ST_LOW  = 15'h0002, S_ST_HIGH  = 15'h0004,
    S_ST_FALL  = 15'h0008, S_TX_LOW  = 15'h0010, S_TX_HIGH  = 15'h0020,
    S_TXA_LOW  = 15'h0040, S_TXA_HIGH = 15'h0080, S_RX_LOW  = 15'h0100,
    S_RX_HIGH  = 15'h0200, S_RXA_LOW = 15'h0400, S_RXA_HIGH = 15'h0800,
    S_SP_LOW   = 15'h1000, S_SP_HIGH = 15'h2000, S_SP_RISE  = 15'h4000
  } seq_t;

  typedef enum logic [2:0] {
    G_DEV = 3'd0, G_WADDR = 3'd1, G_RDEV = 3'd2, G_WDATA = 3'd3,
    G_RDATA = 3'd4, G_POLL = 3'd5, G_STOP = 3'd6, G_STOP_POLL = 3'd7
  } stage_t;

endpackage

[rtl/iem_tick_if.sv]
// ----------------------------------------------------------------------------
// iem_tick_if
// Valid/ready channel carrying one input tick.
// ----------------------------------------------------------------------------
interface iem_tick_if;
  logic          valid;
  logic          ready;
  iem_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/iem_res_if.sv]
// ----------------------------------------------------------------------------
// iem_res_if
// Valid/ready channel carrying one result.
// ----------------------------------------------------------------------------
interface iem_res_if;
  logic          valid;
  logic          ready;
  iem_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/iem_cfg_if.sv]
// ----------------------------------------------------------------------------
// iem_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface iem_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/iem_front.sv]
// ----------------------------------------------------------------------------
// iem_front
// Accepts ticks and holds them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module iem_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  iem_pkg::tick_t in_data,
  output logic           q_valid,
  input  logic           q_pop,
  output iem_pkg::tick_t q_data
);

  iem_pkg::tick_t mem_r [2];
  logic           wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the accepted transaction
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

endmodule

[rtl/iem_back.sv]
// ----------------------------------------------------------------------------
// iem_back
// Bus sequencer: runs one tick per cycle unless a held result stalls it, and registers the result.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_master_assert.svh"
module iem_back #(
  parameter int PAGE_BYTES = iem_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_WIDTH = iem_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  iem_pkg::tick_t q_data,
  input  logic [15:0]    phase_ticks,
  input  logic [7:0]     stretch_limit,
  output logic           r_valid,
  input  logic           r_ready,
  output iem_pkg::res_t  r_data
);

  localparam int PIW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

  iem_pkg::seq_t   seq_r, seq_nxt;
  iem_pkg::stage_t stage_r, stage_nxt;
  logic [15:0]     ph_r, ph_nxt;
  logic [3:0]      bit_r, bit_nxt;
  logic [7:0]      sh_r, sh_nxt;
  logic [4:0]      bc_r, bc_nxt;
  logic [7:0]      sc_r, sc_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [2:0]      cmd_r, cmd_nxt;
  logic [7:0]      hd_r, hd_nxt;
  logic [2:0]      pend_r, pend_nxt;
  logic [7:0]      pbuf_r [PAGE_BYTES];
  logic [7:0]      pb_rd_r;
  logic            ov_r;
  iem_pkg::res_t   od_r, res;

  logic        step, done, rv, wr_buf, nack;
  logic [2:0]  st;
  logic [7:0]  rd, devb, addr_lo;
  logic [3:0]  ri;
  logic [15:0] ticks;
  logic [7:0]  limit;
  logic [4:0]  total;
  logic [10:0] addr_full;
  logic [7:0]  rx_byte;
  logic [4:0]  pb_idx;

  assign q_pop   = q_valid && (!ov_r || r_ready);
  assign step    = q_pop;
  assign r_valid = ov_r;
  assign r_data  = od_r;

  assign ticks = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign limit = (stretch_limit == 8'd0) ? 8'd1 : stretch_limit;
  assign total = (cmd_r == iem_pkg::MODE_RDP || cmd_r == iem_pkg::MODE_WRP) ?
                 5'(PAGE_BYTES) : 5'd1;
  assign addr_full = 11'(addr_r);
  assign devb      = {4'd0, addr_full[10:8], 1'b0};
  assign addr_lo   = addr_full[7:0];
  assign nack      = q_data.sda_in;
  assign rx_byte   = {sh_r[6:0], q_data.sda_in};

  // Point the buffer read at the byte that the next data ack will send
  assign pb_idx = (stage_r == iem_pkg::G_WDATA) ? bc_r + 5'd1 : 5'd0;

  // Sequence one tick
  always_comb begin
    seq_nxt = seq_r; stage_nxt = stage_r; ph_nxt = ph_r; bit_nxt = bit_r;
    sh_nxt = sh_r; bc_nxt = bc_r; sc_nxt = sc_r; addr_nxt = addr_r;
    cmd_nxt = cmd_r; hd_nxt = hd_r; pend_nxt = pend_r;
    done = 1'b0; rv = 1'b0; st = iem_pkg::ST_OK; rd = 8'd0; ri = 4'd0;
    wr_buf = 1'b0;
    if (seq_r == iem_pkg::S_IDLE) begin
      if (q_data.mode >= iem_pkg::MODE_RDB && q_data.mode <= iem_pkg::MODE_WRP) begin
        cmd_nxt = q_data.mode; addr_nxt = q_data.address[ADDR_WIDTH-1:0];
        hd_nxt = q_data.write_data; stage_nxt = iem_pkg::G_DEV;
        pend_nxt = iem_pkg::ST_OK; ph_nxt = 16'd0; bit_nxt = 4'd0;
        bc_nxt = 5'd0; sc_nxt = 8'd0; seq_nxt = iem_pkg::S_ST_HIGH;
      end else if (q_data.mode == iem_pkg::MODE_LOAD) begin
        wr_buf = ({1'b0, q_data.buffer_index} < 5'(PAGE_BYTES));
        done = 1'b1;
      end
    end else if (seq_r == iem_pkg::S_RX_HIGH && !q_data.scl_in) begin
      sc_nxt = sc_r + 8'd1;
      if (sc_nxt >= limit) begin
        ph_nxt = 16'd0; pend_nxt = iem_pkg::ST_TIMEOUT;
        stage_nxt = iem_pkg::G_STOP; seq_nxt = iem_pkg::S_SP_LOW;
      end
    end else if ({1'b0, ph_r} + 17'd1 < {1'b0, ticks}) begin
      ph_nxt = ph_r + 16'd1;
    end else begin
      ph_nxt = 16'd0;
      case (seq_r)
        iem_pkg::S_ST_LOW:  seq_nxt = iem_pkg::S_ST_HIGH;
        iem_pkg::S_ST_HIGH: seq_nxt = iem_pkg::S_ST_FALL;
        iem_pkg::S_ST_FALL: begin
          bit_nxt = 4'd0; seq_nxt = iem_pkg::S_TX_LOW;
          if (stage_r == iem_pkg::G_DEV) sh_nxt = iem_pkg::DEV_WR | devb;
          else if (stage_r == iem_pkg::G_RDEV) sh_nxt = iem_pkg::DEV_RD | devb;
          else sh_nxt = iem_pkg::DEV_WR;
        end
        iem_pkg::S_TX_LOW: seq_nxt = iem_pkg::S_TX_HIGH;
        iem_pkg::S_TX_HIGH: begin
          sh_nxt = {sh_r[6:0], 1'b0}; bit_nxt = bit_r + 4'd1;
          seq_nxt = (bit_nxt >= 4'd8) ? iem_pkg::S_TXA_LOW : iem_pkg::S_TX_LOW;
        end
        iem_pkg::S_TXA_LOW: seq_nxt = iem_pkg::S_TXA_HIGH;
        iem_pkg::S_TXA_HIGH: begin
          case (stage_r)
            iem_pkg::G_DEV: begin
              if (nack) begin
                pend_nxt = iem_pkg::ST_DEVNACK; stage_nxt = iem_pkg::G_STOP;
                seq_nxt = iem_pkg::S_SP_LOW;
              end else begin
                stage_nxt = iem_pkg::G_WADDR; sh_nxt = addr_lo; bit_nxt = 4'd0;
                seq_nxt = iem_pkg::S_TX_LOW;
              end
            end
            iem_pkg::G_WADDR: begin
              if (nack) begin
                pend_nxt = iem_pkg::ST_WANACK; stage_nxt = iem_pkg::G_STOP;
                seq_nxt = iem_pkg::S_SP_LOW;
              end else if (cmd_r == iem_pkg::MODE_RDB || cmd_r == iem_pkg::MODE_RDP) begin
                stage_nxt = iem_pkg::G_RDEV; seq_nxt = iem_pkg::S_ST_LOW;
              end else begin
                stage_nxt = iem_pkg::G_WDATA; bc_nxt = 5'd0; bit_nxt = 4'd0;
                sh_nxt = (cmd_r == iem_pkg::MODE_WRB) ? hd_r : pb_rd_r;
                seq_nxt = iem_pkg::S_TX_LOW;
              end
            end
            iem_pkg::G_RDEV: begin
              if (nack) begin
                pend_nxt = iem_pkg::ST_RDNACK; stage_nxt = iem_pkg::G_STOP;
                seq_nxt = iem_pkg::S_SP_LOW;
              end else begin
                stage_nxt = iem_pkg::G_RDATA; bc_nxt = 5'd0; bit_nxt = 4'd0;
                sc_nxt = 8'd0; seq_nxt = iem_pkg::S_RX_LOW;
              end
            end
            iem_pkg::G_WDATA: begin
              if (nack) begin
                pend_nxt = iem_pkg::ST_DATNACK; stage_nxt = iem_pkg::G_STOP;
                seq_nxt = iem_pkg::S_SP_LOW;
              end else begin
                bc_nxt = bc_r + 5'd1;
                if (bc_nxt >= total) begin
                  pend_nxt = iem_pkg::ST_OK; stage_nxt = iem_pkg::G_STOP_POLL;
                  seq_nxt = iem_pkg::S_SP_LOW;
                end else begin
                  sh_nxt = pb_rd_r; bit_nxt = 4'd0;
                  seq_nxt = iem_pkg::S_TX_LOW;
                end
              end
            end
            default: begin
              if (nack) seq_nxt = iem_pkg::S_ST_LOW;
              else begin
                pend_nxt = iem_pkg::ST_OK; stage_nxt = iem_pkg::G_STOP;
                seq_nxt = iem_pkg::S_SP_LOW;
              end
            end
          endcase
        end
        iem_pkg::S_RX_LOW: seq_nxt = iem_pkg::S_RX_HIGH;
        iem_pkg::S_RX_HIGH: begin
          sh_nxt = rx_byte; bit_nxt = bit_r + 4'd1;
          if (bit_nxt >= 4'd8) begin
            rv = 1'b1; rd = rx_byte; ri = bc_r[3:0];
            seq_nxt = iem_pkg::S_RXA_LOW;
          end else begin
            seq_nxt = iem_pkg::S_RX_LOW;
          end
        end
        iem_pkg::S_RXA_LOW: seq_nxt = iem_pkg::S_RXA_HIGH;
        iem_pkg::S_RXA_HIGH: begin
          bc_nxt = bc_r + 5'd1;
          if (bc_nxt >= total) begin
            pend_nxt = iem_pkg::ST_OK; stage_nxt = iem_pkg::G_STOP;
            seq_nxt = iem_pkg::S_SP_LOW;
          end else begin
            bit_nxt = 4'd0; sc_nxt = 8'd0; seq_nxt = iem_pkg::S_RX_LOW;
          end
        end
        iem_pkg::S_SP_LOW:  seq_nxt = iem_pkg::S_SP_HIGH;
        iem_pkg::S_SP_HIGH: seq_nxt = iem_pkg::S_SP_RISE;
        iem_pkg::S_SP_RISE: begin
          if (stage_r == iem_pkg::G_STOP_POLL) begin
            stage_nxt = iem_pkg::G_POLL; seq_nxt = iem_pkg::S_ST_HIGH;
          end else begin
            seq_nxt = iem_pkg::S_IDLE; done = 1'b1; st = pend_r;
          end
        end
        default: seq_nxt = iem_pkg::S_IDLE;
      endcase
    end
  end

  // Drive the lines from the next state
  always_comb begin
    res = '0;
    res.scl_release = 1'b1;
    res.sda_release = 1'b1;
    case (seq_nxt)
      iem_pkg::S_ST_LOW: res.scl_release = 1'b0;
      iem_pkg::S_ST_FALL: res.sda_release = 1'b0;
      iem_pkg::S_TX_LOW: begin
        res.scl_release = 1'b0; res.sda_release = sh_nxt[7];
      end
      iem_pkg::S_TX_HIGH: res.sda_release = sh_nxt[7];
      iem_pkg::S_TXA_LOW, iem_pkg::S_RX_LOW: res.scl_release = 1'b0;
      iem_pkg::S_RXA_LOW: begin
        res.scl_release = 1'b0; res.sda_release = (bc_nxt + 5'd1 >= total);
      end
      iem_pkg::S_RXA_HIGH: res.sda_release = (bc_nxt + 5'd1 >= total);
      iem_pkg::S_SP_LOW: begin
        res.scl_release = 1'b0; res.sda_release = 1'b0;
      end
      iem_pkg::S_SP_HIGH: res.sda_release = 1'b0;
      default: res.sda_release = 1'b1;
    endcase
    res.busy_res   = (seq_nxt != iem_pkg::S_IDLE);
    res.done_res   = done;
    res.status     = st;
    res.read_data  = rd;
    res.read_valid = rv;
    res.read_index = ri;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= iem_pkg::S_IDLE; stage_r <= iem_pkg::G_DEV; ph_r <= '0;
      bit_r <= '0; sh_r <= '0; bc_r <= '0; sc_r <= '0; addr_r <= '0;
      cmd_r <= '0; hd_r <= '0; pend_r <= '0; ov_r <= 1'b0;
    end else begin
      if (step) begin
        seq_r <= seq_nxt; stage_r <= stage_nxt; ph_r <= ph_nxt;
        bit_r <= bit_nxt; sh_r <= sh_nxt; bc_r <= bc_nxt; sc_r <= sc_nxt;
        addr_r <= addr_nxt; cmd_r <= cmd_nxt; hd_r <= hd_nxt;
        pend_r <= pend_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (r_ready) ov_r <= 1'b0;
    end
  end

  // Hold the result and the page buffer; fetch the next page byte ahead
  always_ff @(posedge clk) begin
    if (step) od_r <= res;
    if (step && wr_buf) pbuf_r[q_data.buffer_index[PIW-1:0]] <= q_data.write_data;
    pb_rd_r <= pbuf_r[pb_idx[PIW-1:0]];
  end

  `IEM_ASSERT_IMP(a_hold, ov_r && !r_ready, !q_pop, "result overwritten while held")
  `IEM_ASSERT_IMP(a_done_idle, ov_r && od_r.done_res, !od_r.busy_res,
                  "done reported while still busy")
  `IEM_ASSERT_IMP(a_rv_idx, ov_r && !od_r.read_valid, od_r.read_index == 4'd0,
                  "read index set without data")
  `IEM_ASSERT_NXT(a_step_valid, step, ov_r, "stepped without result")

endmodule

[rtl/i2c_eeprom_master.sv]
// Ticks pass the input queue; the sequencer registers each result. Throughput:
// one tick per cycle unless a held result stalls; the sequencer steps once per
// queued tick. A two-entry input queue and the output register decouple the
// two sides. Reset (rst_n low, synchronous) idles the sequencer and empties
// the queue; the page buffer holds its contents until loaded.
// ----------------------------------------------------------------------------
// i2c_eeprom_master
// Top level of the tick-driven I2C EEPROM master.
// ----------------------------------------------------------------------------
module i2c_eeprom_master #(
  parameter int PAGE_BYTES = iem_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_WIDTH = iem_pkg::ADDR_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  iem_tick_if.sink   in_ch,
  iem_res_if.source  out_ch,
  iem_cfg_if.sink    cfg_ch
);

  logic           q_valid, q_pop;
  iem_pkg::tick_t q_data;
  logic [15:0]    phase_r;
  logic [7:0]     limit_r;

  // Accept configuration writes at any time
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 16'd1;
      limit_r <= 8'd255;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == iem_pkg::CFG_PHASE) phase_r <= cfg_ch.wdata;
      else limit_r <= cfg_ch.wdata[7:0];
    end
  end

  iem_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  iem_back #(.PAGE_BYTES(PAGE_BYTES), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .phase_ticks(phase_r), .stretch_limit(limit_r),
    .r_valid(out_ch.valid), .r_ready(out_ch.ready), .r_data(out_ch.data)
  );

endmodule

[verif/i2c_eeprom_master_test.sv]
// ----------------------------------------------------------------------------
// i2c_eeprom_master_test
// Self-checking bench for the tick-driven I2C EEPROM master. A planning copy
// of the bus sequencer shapes each tick (acks, NACKs, clock stretching, read
// bits), and a second copy predicts every result as ticks are accepted.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_test;
  import iem_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int         HOLD_TICKS  = 250;
  localparam int         CYCLE_LIMIT = 3000000;

  typedef struct {
    seq_t        sq;
    stage_t      stg;
    logic [15:0] pcnt;
    logic [3:0]  bcnt;
    logic [7:0]  shreg;
    logic [4:0]  bytes;
    logic [7:0]  scnt;
    logic [10:0] addr;
    logic [2:0]  cmd;
    logic [7:0]  wbyte;
    logic [2:0]  pend;
    logic [7:0]  pbuf [16];
    logic [15:0] phase_ticks;
    logic [7:0]  stretch_limit;
  } eeprom_seq_t;

  logic clk;
  logic rst_n;
  iem_tick_if in_ch();
  iem_res_if  out_ch();
  iem_cfg_if  cfg_ch();

  i2c_eeprom_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  eeprom_seq_t plan_m;
  eeprom_seq_t check_m;
  res_t        plan_lines;
  tick_t       tick_q [$];
  res_t        result_q [$];
  bit          failed;
  int          cycle;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  bit          calm;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic void seq_reset(inout eeprom_seq_t m);
    m.sq = S_IDLE; m.stg = G_DEV; m.pcnt = '0; m.bcnt = '0; m.shreg = '0;
    m.bytes = '0; m.scnt = '0; m.addr = '0; m.cmd = '0; m.wbyte = '0;
    m.pend = ST_OK; m.phase_ticks = 16'd1; m.stretch_limit = 8'd255;
    for (int i = 0; i < 16; i++) m.pbuf[i] = '0;
  endfunction

  function automatic int page_len(eeprom_seq_t m);
    return (m.cmd == MODE_RDP || m.cmd == MODE_WRP) ? 16 : 1;
  endfunction

  function automatic void go_stop(inout eeprom_seq_t m, input logic [2:0] code,
                                  input stage_t nxt);
    m.pend = code;
    m.stg  = nxt;
    m.sq   = S_SP_LOW;
  endfunction

  function automatic void send_byte(inout eeprom_seq_t m, input logic [7:0] b);
    m.shreg = b;
    m.bcnt  = '0;
    m.sq    = S_TX_LOW;
  endfunction

  // Act on the ack bit that closes a transmitted byte
  function automatic void ack_seen(inout eeprom_seq_t m, input logic nack);
    case (m.stg)
      G_DEV: begin
        if (nack) go_stop(m, ST_DEVNACK, G_STOP);
        else begin
          m.stg = G_WADDR;
          send_byte(m, m.addr[7:0]);
        end
      end
      G_WADDR: begin
        if (nack) go_stop(m, ST_WANACK, G_STOP);
        else if (m.cmd == MODE_RDB || m.cmd == MODE_RDP) begin
          m.stg = G_RDEV;
          m.sq  = S_ST_LOW;
        end else begin
          m.stg = G_WDATA;
          m.bytes = '0;
          send_byte(m, m.cmd == MODE_WRB ? m.wbyte : m.pbuf[0]);
        end
      end
      G_RDEV: begin
        if (nack) go_stop(m, ST_RDNACK, G_STOP);
        else begin
          m.stg = G_RDATA; m.bytes = '0; m.bcnt = '0; m.scnt = '0;
          m.sq = S_RX_LOW;
        end
      end
      G_WDATA: begin
        if (nack) go_stop(m, ST_DATNACK, G_STOP);
        else begin
          m.bytes++;
          if (m.bytes >= page_len(m)) go_stop(m, ST_OK, G_STOP_POLL);
          else send_byte(m, m.pbuf[m.bytes[3:0]]);
        end
      end
      default: begin
        if (nack) m.sq = S_ST_LOW;
        else go_stop(m, ST_OK, G_STOP);
      end
    endcase
  endfunction

  function automatic void phase_end(inout eeprom_seq_t m, input logic sda,
                                    inout res_t r);
    logic [7:0] dev;
    dev = {4'b0000, m.addr[10:8], 1'b0};
    case (m.sq)
      S_ST_LOW:  m.sq = S_ST_HIGH;
      S_ST_HIGH: m.sq = S_ST_FALL;
      S_ST_FALL: begin
        if (m.stg == G_DEV) send_byte(m, DEV_WR | dev);
        else if (m.stg == G_RDEV) send_byte(m, DEV_RD | dev);
        else send_byte(m, DEV_WR);
      end
      S_TX_LOW:  m.sq = S_TX_HIGH;
      S_TX_HIGH: begin
        m.shreg = m.shreg << 1;
        m.bcnt++;
        m.sq = (m.bcnt >= 8) ? S_TXA_LOW : S_TX_LOW;
      end
      S_TXA_LOW:  m.sq = S_TXA_HIGH;
      S_TXA_HIGH: ack_seen(m, sda);
      S_RX_LOW:   m.sq = S_RX_HIGH;
      S_RX_HIGH: begin
        m.shreg = {m.shreg[6:0], sda};
        m.bcnt++;
        if (m.bcnt >= 8) begin
          r.read_valid = 1'b1;
          r.read_data  = m.shreg;
          r.read_index = m.bytes[3:0];
          m.sq = S_RXA_LOW;
        end else begin
          m.sq = S_RX_LOW;
        end
      end
      S_RXA_LOW:  m.sq = S_RXA_HIGH;
      S_RXA_HIGH: begin
        m.bytes++;
        if (m.bytes >= page_len(m)) go_stop(m, ST_OK, G_STOP);
        else begin
          m.bcnt = '0; m.scnt = '0; m.sq = S_RX_LOW;
        end
      end
      S_SP_LOW:  m.sq = S_SP_HIGH;
      S_SP_HIGH: m.sq = S_SP_RISE;
      S_SP_RISE: begin
        if (m.stg == G_STOP_POLL) begin
          m.stg = G_POLL;
          m.sq  = S_ST_HIGH;
        end else begin
          m.sq = S_IDLE;
          r.done_res = 1'b1;
          r.status   = m.pend;
        end
      end
      default: m.sq = S_IDLE;
    endcase
  endfunction

  // Advance the sequencer by one tick and form the line drives and status
  function automatic void seq_tick(inout eeprom_seq_t m, input tick_t t,
                                   output res_t r);
    int  ticks;
    int  lim;
    logic last_rx;
    ticks = (m.phase_ticks == 16'd0) ? 1 : int'(m.phase_ticks);
    lim   = (m.stretch_limit == 8'd0) ? 1 : int'(m.stretch_limit);
    r = '0;
    if (m.sq == S_IDLE) begin
      if (t.mode >= MODE_RDB && t.mode <= MODE_WRP) begin
        m.cmd = t.mode; m.addr = t.address; m.wbyte = t.write_data;
        m.stg = G_DEV; m.pend = ST_OK; m.pcnt = '0; m.bcnt = '0;
        m.bytes = '0; m.scnt = '0; m.sq = S_ST_HIGH;
      end else if (t.mode == MODE_LOAD) begin
        m.pbuf[t.buffer_index] = t.write_data;
        r.done_res = 1'b1;
      end
    end else if (m.sq == S_RX_HIGH && !t.scl_in) begin
      m.scnt++;
      if (m.scnt >= lim) begin
        m.pcnt = '0;
        go_stop(m, ST_TIMEOUT, G_STOP);
      end
    end else if (int'(m.pcnt) + 1 < ticks) begin
      m.pcnt++;
    end else begin
      m.pcnt = '0;
      phase_end(m, t.sda_in, r);
    end
    last_rx = (int'(m.bytes) + 1 >= page_len(m));
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    case (m.sq)
      S_ST_LOW:  r.scl_release = 1'b0;
      S_ST_FALL: r.sda_release = 1'b0;
      S_TX_LOW:  begin r.scl_release = 1'b0; r.sda_release = m.shreg[7]; end
      S_TX_HIGH: r.sda_release = m.shreg[7];
      S_TXA_LOW, S_RX_LOW: r.scl_release = 1'b0;
      S_RXA_LOW: begin r.scl_release = 1'b0; r.sda_release = last_rx; end
      S_RXA_HIGH: r.sda_release = last_rx;
      S_SP_LOW:  begin r.scl_release = 1'b0; r.sda_release = 1'b0; end
      S_SP_HIGH: r.sda_release = 1'b0;
      default: ;
    endcase
    r.busy_res = (m.sq != S_IDLE);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tick driver: offer the oldest pending tick, drop it once taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    calm <= (cycle >= 3000 && cycle < 6000);
    if (rst_n && tick_q.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
      in_ch.valid <= 1'b1;
      in_ch.data  <= tick_q[0];
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result sink: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_TICKS;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results, then predict from the accepted tick
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t pred;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (result_q.size() == 0) begin
        $error("result with no transaction pending: %h", got);
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (got.scl_release !== want.scl_release) begin
          $error("scl_release exp %0d got %0d", want.scl_release, got.scl_release);
          failed = 1'b1;
        end
        if (got.sda_release !== want.sda_release) begin
          $error("sda_release exp %0d got %0d", want.sda_release, got.sda_release);
          failed = 1'b1;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res exp %0d got %0d", want.busy_res, got.busy_res);
          failed = 1'b1;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res exp %0d got %0d", want.done_res, got.done_res);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          failed = 1'b1;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data exp %h got %h", want.read_data, got.read_data);
          failed = 1'b1;
        end
        if (got.read_valid !== want.read_valid) begin
          $error("read_valid exp %0d got %0d", want.read_valid, got.read_valid);
          failed = 1'b1;
        end
        if (got.read_index !== want.read_index) begin
          $error("read_index exp %0d got %0d", want.read_index, got.read_index);
          failed = 1'b1;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seq_tick(check_m, in_ch.data, pred);
      result_q.push_back(pred);
      void'(tick_q.pop_front());
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  // Shape one tick as the EEPROM and bus would answer, then queue it
  task automatic plan_tick(input logic [2:0] md, input logic [10:0] a,
                           input logic [7:0] wd, input logic [3:0] bi,
                           input stage_t nack_stage, input int stretch_pct);
    tick_t t;
    res_t  r;
    t.mode = md; t.address = a; t.write_data = wd; t.buffer_index = bi;
    t.scl_in = plan_lines.scl_release;
    t.sda_in = plan_lines.sda_release;
    if (plan_m.sq == S_TXA_HIGH)
      t.sda_in = (plan_m.stg == G_POLL) ? 1'($urandom_range(1))
                                        : (plan_m.stg == nack_stage);
    if (plan_m.sq == S_RX_HIGH) begin
      t.sda_in = 1'($urandom_range(1));
      if ($urandom_range(99) < stretch_pct) t.scl_in = 1'b0;
    end
    tick_q.push_back(t);
    seq_tick(plan_m, t, r);
    plan_lines = r;
  endtask

  function automatic logic [2:0] quiet_mode();
    int k;
    k = $urandom_range(2);
    return (k == 0) ? MODE_TICK : (k == 1) ? MODE_SPARE6 : MODE_SPARE7;
  endfunction

  // Issue one command, tick it through to completion, then a short gap
  task automatic plan_cmd(input logic [2:0] md, input logic [10:0] a,
                          input logic [7:0] wd, input logic [3:0] bi,
                          input stage_t nack_stage, input int stretch_pct);
    logic [2:0] bm;
    plan_tick(md, a, wd, bi, nack_stage, stretch_pct);
    while (plan_m.sq != S_IDLE) begin
      bm = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : MODE_TICK;
      plan_tick(bm, 11'($urandom_range(2047)), 8'($urandom_range(255)),
                4'($urandom_range(15)), nack_stage, stretch_pct);
    end
    repeat ($urandom_range(3))
      plan_tick(quiet_mode(), 11'($urandom_range(2047)), 8'($urandom_range(255)),
                4'($urandom_range(15)), nack_stage, stretch_pct);
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || result_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register while idle and mirror it in both model copies
  task automatic cfg_write(input logic idx, input logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_PHASE) begin
      plan_m.phase_ticks = val; check_m.phase_ticks = val;
    end else begin
      plan_m.stretch_limit = val[7:0]; check_m.stretch_limit = val[7:0];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_cmds(input int n);
    int k;
    stage_t ns;
    int sp;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      ns = ($urandom_range(9) == 0) ? stage_t'($urandom_range(3)) : G_STOP;
      sp = ($urandom_range(3) == 0) ? 30 : 0;
      if (k < 2)
        plan_cmd(MODE_LOAD, 11'($urandom_range(2047)), 8'($urandom_range(255)),
                 4'($urandom_range(15)), ns, sp);
      else if (k == 9)
        plan_cmd(quiet_mode(), 11'($urandom_range(2047)), 8'($urandom_range(255)),
                 4'($urandom_range(15)), ns, sp);
      else
        plan_cmd(3'($urandom_range(MODE_WRP, MODE_RDB)), 11'($urandom_range(2047)),
                 8'($urandom_range(255)), 4'($urandom_range(15)), ns, sp);
    end
  endtask

  initial begin
    failed = 1'b0; cycle = 0; hold_req = 0; hold_seen = 0; hold_left = 0;
    calm = 1'b0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_PHASE; cfg_ch.wdata = '0;
    seq_reset(plan_m);
    seq_reset(check_m);
    plan_lines = '0;
    plan_lines.scl_release = 1'b1;
    plan_lines.sda_release = 1'b1;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole page buffer first, extremes at both ends
    plan_cmd(MODE_LOAD, 11'd0, 8'h00, 4'd0, G_STOP, 0);
    plan_cmd(MODE_LOAD, 11'd2047, 8'hff, 4'd15, G_STOP, 0);
    for (int i = 1; i < 15; i++)
      plan_cmd(MODE_LOAD, 11'($urandom_range(2047)), 8'($urandom_range(255)), 4'(i),
               G_STOP, 0);
    // Every command, each NACK point, unused modes and clock stretching
    plan_cmd(MODE_RDB, 11'd0, 8'h00, 4'd0, G_STOP, 0);
    plan_cmd(MODE_WRB, 11'd2047, 8'hff, 4'd15, G_STOP, 0);
    plan_cmd(MODE_RDP, 11'h5a5, 8'h00, 4'd0, G_STOP, 20);
    plan_cmd(MODE_WRP, 11'h2aa, 8'h00, 4'd0, G_STOP, 0);
    plan_cmd(MODE_WRB, 11'h100, 8'h3c, 4'd0, G_DEV, 0);
    plan_cmd(MODE_RDB, 11'h200, 8'h00, 4'd0, G_WADDR, 0);
    plan_cmd(MODE_RDB, 11'h400, 8'h00, 4'd0, G_RDEV, 0);
    plan_cmd(MODE_WRP, 11'h7f0, 8'h00, 4'd0, G_WDATA, 0);
    plan_cmd(MODE_SPARE6, 11'h123, 8'h55, 4'd3, G_STOP, 0);
    plan_cmd(MODE_SPARE7, 11'h321, 8'haa, 4'd12, G_STOP, 0);

    cfg_write(CFG_LIMIT, 16'd1);
    plan_cmd(MODE_RDB, 11'h0f0, 8'h00, 4'd0, G_STOP, 50);
    cfg_write(CFG_PHASE, 16'd65535);
    plan_cmd(MODE_LOAD, 11'd0, 8'h81, 4'd7, G_STOP, 0);
    for (int i = 0; i < 20; i++)
      plan_tick(quiet_mode(), 11'd0, 8'd0, 4'd0, G_STOP, 0);
    cfg_write(CFG_PHASE, 16'd2);
    cfg_write(CFG_LIMIT, 16'd40);
    random_cmds(8);

    // Long receiver hold-off while ticks keep coming
    drain();
    hold_req = hold_req + 1;
    plan_cmd(MODE_RDP, 11'($urandom_range(2047)), 8'h00, 4'd0, G_STOP, 10);
    random_cmds(6);
    // Sender waits for every outstanding result mid-phase
    while (result_q.size() > 0 || tick_q.size() > 0) @(posedge clk);
    random_cmds(6);

    cfg_write(CFG_PHASE, 16'd1);
    cfg_write(CFG_LIMIT, 16'd255);
    random_cmds(14);
    cfg_write(CFG_PHASE, 16'd3);
    cfg_write(CFG_LIMIT, 16'd7);
    random_cmds(8);

    drain();
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
